### rtl/glmt_pkg.sv
// ----------------------------------------------------------------------------
// glmt_pkg
// Shared types and codes of the greedy longest-match tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package glmt_pkg;

  // Operation codes carried in the input tuser field.
  localparam logic [1:0] OP_TEXT      = 2'd0;
  localparam logic [1:0] OP_WR_BYTE   = 2'd1;
  localparam logic [1:0] OP_WR_LEN_ID = 2'd2;

  localparam int unsigned OUT_ID_W = 18;

  // Per-cell control of the window chain.
  typedef struct packed {
    logic load;   // capture the incoming text byte
    logic shift;  // take the byte of the right-hand neighbor
  } cell_ctrl_t;

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_SCAN  = 5'b00100,
    ST_EMIT  = 5'b01000,
    ST_SHIFT = 5'b10000
  } state_e;

endpackage

`default_nettype wire

### rtl/glmt_cell.sv
// ----------------------------------------------------------------------------
// glmt_cell
// One byte of the text window with its vocabulary byte comparator.
// ----------------------------------------------------------------------------
`default_nettype none

module glmt_cell (
  input  wire                  clk_i,
  input  glmt_pkg::cell_ctrl_t ctrl_i,
  input  wire  [7:0]           text_byte_i,
  input  wire  [7:0]           right_byte_i,
  input  wire  [7:0]           row_byte_i,
  output logic [7:0]           byte_o,
  output logic                 eq_o
);
  import glmt_pkg::*;

  logic [7:0] byte_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      byte_q <= text_byte_i;
    end else if (ctrl_i.shift) begin
      byte_q <= right_byte_i;
    end
  end

  assign byte_o = byte_q;
  assign eq_o   = (byte_q == row_byte_i);

endmodule

`default_nettype wire

### rtl/greedy_longest_match_tokenizer_core.sv
// ----------------------------------------------------------------------------
// greedy_longest_match_tokenizer_core
// Greedy longest-match tokenizer with raw-byte fallback.
// ----------------------------------------------------------------------------
// Vocabulary entries are loaded through write transactions (entry bytes, then
// length and id); text bytes then collect in a window held by a row of byte
// cells. When the window fills, or a byte arrives with tlast, the vocabulary
// is scanned one entry per cycle against the window and the longest matching
// entry (the higher index on a tie) is emitted; with no match the first byte
// is emitted with tuser set. Matched bytes leave by shifting the cell row one
// position per cycle. At end of text the window is drained and the final
// token carries tlast. Each token takes a full scan of the vocabulary, an emit
// step and one shift per dropped byte; the scan, bound by the single read
// port of the vocabulary memory, dominates. After reset a clearing pass
// marks every entry invalid, and no transaction is accepted until it ends.
// Input is accepted only while no token is in work.
// ----------------------------------------------------------------------------
`default_nettype none

module greedy_longest_match_tokenizer_core #(
  parameter int unsigned MAX_TOKEN_LEN = 32,
  parameter int unsigned VOCAB_ENTRIES = 1024,
  parameter int unsigned TOKEN_ID_BITS = 18
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // byte_value[7:0], entry_index[17:8], byte_position[22:18],
  // entry_length[28:23], entry_token_id[46:29], zero pad[47]
  input  wire  [47:0] s_axis_tdata_i,
  input  wire  [1:0]  s_axis_tuser_i,   // operation[1:0]
  input  wire         s_axis_tlast_i,   // end_of_text
  output logic        m_axis_tvalid_o,
  input  wire         m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // token[17:0], zero pad[23:18]
  output logic        m_axis_tuser_o,   // is_fallback
  output logic        m_axis_tlast_o    // last_of_run
);
  import glmt_pkg::*;

  localparam int unsigned AW   = (VOCAB_ENTRIES > 1) ? $clog2(VOCAB_ENTRIES) : 1;
  localparam int unsigned PW   = (MAX_TOKEN_LEN > 1) ? $clog2(MAX_TOKEN_LEN) : 1;
  localparam int unsigned CW   = $clog2(MAX_TOKEN_LEN + 1);
  localparam int unsigned ROWW = MAX_TOKEN_LEN * 8;
  localparam int unsigned IDW  = (TOKEN_ID_BITS < OUT_ID_W) ? TOKEN_ID_BITS : OUT_ID_W;
  localparam int unsigned LIW  = 6 + IDW;

  // Input fields.
  logic [7:0]  in_byte;
  logic [9:0]  in_index;
  logic [4:0]  in_pos;
  logic [5:0]  in_len;
  logic [17:0] in_tid;
  assign in_byte  = s_axis_tdata_i[7:0];
  assign in_index = s_axis_tdata_i[17:8];
  assign in_pos   = s_axis_tdata_i[22:18];
  assign in_len   = s_axis_tdata_i[28:23];
  assign in_tid   = s_axis_tdata_i[46:29];

  state_e state_q, state_d;
  logic   accept;
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign accept = s_axis_tvalid_i & s_axis_tready_o;

  logic idx_ok, pos_ok;
  assign idx_ok = ({22'd0, in_index} < 32'(VOCAB_ENTRIES));
  assign pos_ok = ({27'd0, in_pos} < 32'(MAX_TOKEN_LEN));

  // Control registers.
  logic [AW-1:0] clr_addr_q;
  logic [AW:0]   scan_q;
  logic          rd_vld_q, rd_last_q;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] left_q;
  logic          drain_q;
  logic [5:0]    best_len_q;
  logic [IDW-1:0] best_id_q;
  logic          out_vld_q;
  logic [17:0]   out_id_q;
  logic          out_fb_q, out_last_q;

  // Vocabulary memories: entry bytes as one row per entry, and {length, id}.
  logic [ROWW-1:0] vocab_mem [VOCAB_ENTRIES];
  logic [LIW-1:0]  lenid_mem [VOCAB_ENTRIES];
  logic [ROWW-1:0] row_q;
  logic [LIW-1:0]  lenid_q;

  logic          issue;
  logic [AW-1:0] wr_addr;
  logic [PW-1:0] wr_pos;
  assign issue   = (state_q == ST_SCAN) && (scan_q < (AW+1)'(VOCAB_ENTRIES));
  assign wr_addr = AW'(in_index);
  assign wr_pos  = PW'(in_pos);

  always_ff @(posedge clk_i) begin
    if (accept && (s_axis_tuser_i == OP_WR_BYTE) && idx_ok && pos_ok) begin
      vocab_mem[wr_addr][wr_pos*8 +: 8] <= in_byte;
    end
    if (issue) begin
      row_q <= vocab_mem[scan_q[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_CLEAR) begin
      lenid_mem[clr_addr_q] <= '0;
    end else if (accept && (s_axis_tuser_i == OP_WR_LEN_ID) && idx_ok) begin
      lenid_mem[wr_addr] <= {in_len, in_tid[IDW-1:0]};
    end
    if (issue) begin
      lenid_q <= lenid_mem[scan_q[AW-1:0]];
    end
  end

  // Window cell row.
  logic [7:0]         cell_byte [MAX_TOKEN_LEN];
  logic [MAX_TOKEN_LEN-1:0] cell_eq, len_mask;
  logic [5:0]         rd_len;
  assign rd_len = lenid_q[LIW-1 -: 6];

  for (genvar i = 0; i < MAX_TOKEN_LEN; i++) begin : g_cell
    cell_ctrl_t ctrl;
    logic [7:0] right;
    assign ctrl.load  = accept && (s_axis_tuser_i == OP_TEXT) && (CW'(i) == count_q);
    assign ctrl.shift = (state_q == ST_SHIFT);
    if (i == MAX_TOKEN_LEN - 1) begin : g_end
      assign right = 8'd0;
    end else begin : g_mid
      assign right = cell_byte[i+1];
    end
    assign len_mask[i] = (7'(i) < {1'b0, rd_len});
    glmt_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .text_byte_i (in_byte),
      .right_byte_i(right),
      .row_byte_i  (row_q[i*8 +: 8]),
      .byte_o      (cell_byte[i]),
      .eq_o        (cell_eq[i])
    );
  end

  logic hit;
  assign hit = rd_vld_q && (rd_len != 6'd0) && ({1'b0, rd_len} <= 7'(count_q)) &&
               (rd_len >= best_len_q) && (&(cell_eq | ~len_mask));

  // Token emission: bytes dropped and the end-of-run flag.
  logic [CW-1:0] drop;
  logic          out_free;
  assign drop     = (best_len_q == 6'd0) ? CW'(1) : CW'(best_len_q);
  assign out_free = !out_vld_q || m_axis_tready_i;

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_addr_q == AW'(VOCAB_ENTRIES - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept && (s_axis_tuser_i == OP_TEXT)) begin
          count_d = count_q + CW'(1);
          if (s_axis_tlast_i || (count_d == CW'(MAX_TOKEN_LEN))) state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (rd_last_q) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) state_d = ST_SHIFT;
      end
      ST_SHIFT: begin
        count_d = count_q - CW'(1);
        if (left_q == CW'(1)) begin
          state_d = (drain_q && (count_d != '0)) ? ST_SCAN : ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      clr_addr_q <= '0;
      scan_q     <= '0;
      rd_vld_q   <= 1'b0;
      rd_last_q  <= 1'b0;
      count_q    <= '0;
      left_q     <= '0;
      drain_q    <= 1'b0;
      best_len_q <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      rd_vld_q <= issue;
      rd_last_q <= issue && (scan_q == (AW+1)'(VOCAB_ENTRIES - 1));
      if (state_q == ST_CLEAR) clr_addr_q <= clr_addr_q + AW'(1);
      if (issue) scan_q <= scan_q + (AW+1)'(1);
      if (hit) best_len_q <= rd_len;
      if (state_q == ST_IDLE && accept) drain_q <= s_axis_tlast_i;
      if (state_q != ST_SCAN && state_d == ST_SCAN) begin
        scan_q     <= '0;
        best_len_q <= '0;
      end
      if (state_q == ST_EMIT && out_free) begin
        left_q    <= drop;
        out_vld_q <= 1'b1;
      end else begin
        if (state_q == ST_SHIFT) left_q <= left_q - CW'(1);
        if (m_axis_tready_i) out_vld_q <= 1'b0;
      end
    end
  end

  // Output payload and winning id.
  always_ff @(posedge clk_i) begin
    if (hit) best_id_q <= lenid_q[IDW-1:0];
    if (state_q == ST_EMIT && out_free) begin
      out_fb_q   <= (best_len_q == 6'd0);
      out_id_q   <= (best_len_q == 6'd0) ? {10'd0, cell_byte[0]} : 18'(best_id_q);
      out_last_q <= drain_q && (drop == count_q);
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {6'd0, out_id_q};
  assign m_axis_tuser_o  = out_fb_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule

`default_nettype wire

### rtl/glmt_checker.sv
// ----------------------------------------------------------------------------
// glmt_checker
// Port-level checks of the tokenizer core, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

module glmt_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        s_axis_tvalid_i,
  input wire        s_axis_tready_o,
  input wire [47:0] s_axis_tdata_i,
  input wire [1:0]  s_axis_tuser_i,
  input wire        s_axis_tlast_i,
  input wire        m_axis_tvalid_o,
  input wire        m_axis_tready_i,
  input wire [23:0] m_axis_tdata_o,
  input wire        m_axis_tuser_o,
  input wire        m_axis_tlast_o
);
  import glmt_pkg::*;

  // A stalled result transaction keeps its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o) &&
      $stable(m_axis_tlast_o))
    else $error("result payload changed while stalled");

  // A fallback token carries a raw byte value only.
  a_fallback_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tdata_o[23:8] == 16'd0)
    else $error("fallback token wider than a byte");

  // The final text byte starts a drain, during which no input is taken.
  a_drain_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && s_axis_tlast_i && (s_axis_tuser_i == OP_TEXT)
      |=> !s_axis_tready_o)
    else $error("input taken right after end of text");

endmodule

bind greedy_longest_match_tokenizer_core glmt_checker u_glmt_checker (.*);

`default_nettype wire

### dv/greedy_longest_match_tokenizer_core_tb.sv
// ----------------------------------------------------------------------------
// greedy_longest_match_tokenizer_core_tb
// Self-checking testbench for the greedy longest-match tokenizer core.
// ----------------------------------------------------------------------------
// A queue of pending transactions is filled up front with a directed opening
// and then random vocabulary loads, noise and text runs. A clocked driver
// feeds the slave side with random gaps, and a clocked monitor takes tokens
// from the master side under random back-pressure. Every accepted input
// transaction updates a local tokenizer predictor, which pushes the tokens it
// expects. Each output token is checked field by field against the oldest one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module greedy_longest_match_tokenizer_core_tb;
  import glmt_pkg::*;

  localparam int unsigned WIN_LEN    = 32;
  localparam int unsigned N_ENTRIES  = 1024;
  localparam int unsigned CYCLE_CAP  = 1200000;
  localparam int unsigned MAX_ERR_PR = 10;

  typedef struct {
    logic [1:0]  op;
    logic [7:0]  byte_val;
    logic        eot;
    logic [9:0]  idx;
    logic [4:0]  pos;
    logic [5:0]  len;
    logic [17:0] tid;
    bit          drain_first;  // hold this transaction until all tokens are out
  } in_item_t;

  typedef struct {
    logic [17:0] tok_id;
    logic        fallback;
    logic        last;
  } token_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [47:0] s_axis_tdata_i = '0;
  logic [1:0]  s_axis_tuser_i = OP_TEXT;
  logic        s_axis_tlast_i = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [23:0] m_axis_tdata_o;
  logic        m_axis_tuser_o;
  logic        m_axis_tlast_o;

  greedy_longest_match_tokenizer_core u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Predictor state: the text window and the vocabulary as the block holds it.
  logic [7:0]  win_q [WIN_LEN];
  int unsigned win_cnt;
  logic [7:0]  voc_bytes [N_ENTRIES][WIN_LEN];
  logic [5:0]  voc_len [N_ENTRIES];
  logic [17:0] voc_id [N_ENTRIES];

  // Generator bookkeeping: which entry bytes have been written so far.
  bit          gen_written [N_ENTRIES][WIN_LEN];

  in_item_t    pending_q[$];
  token_t      token_q[$];
  int unsigned err_cnt = 0;
  int unsigned cycle_cnt = 0;

  // Finds the longest matching entry at the front of the window, pushes the
  // token it yields and drops the bytes it consumed.
  task automatic emit_token(input bit last);
    int unsigned best_len;
    logic [17:0] best_id;
    bit          hit;
    token_t      tok;
    int unsigned src;
    best_len = 0;
    best_id  = '0;
    hit      = 1'b0;
    for (int e = 0; e < N_ENTRIES; e++) begin
      if (voc_len[e[9:0]] != 6'd0 && 32'(voc_len[e[9:0]]) <= win_cnt &&
          32'(voc_len[e[9:0]]) >= best_len) begin
        hit = 1'b1;
        for (int b = 0; b < 32'(voc_len[e[9:0]]); b++)
          if (voc_bytes[e[9:0]][b[4:0]] !== win_q[b[4:0]]) hit = 1'b0;
        if (hit) begin
          best_len = 32'(voc_len[e[9:0]]);
          best_id  = voc_id[e[9:0]];
        end
      end
    end
    if (best_len > 0) begin
      tok.tok_id   = best_id;
      tok.fallback = 1'b0;
    end else begin
      tok.tok_id   = {10'd0, win_q[0]};
      tok.fallback = 1'b1;
      best_len     = 1;
    end
    tok.last = last;
    token_q  = {token_q, tok};
    for (int b = 0; b < WIN_LEN; b++) begin
      src = b + best_len;
      win_q[b[4:0]] = (src < win_cnt) ? win_q[src[4:0]] : 8'd0;
    end
    win_cnt -= best_len;
  endtask

  // Applies one accepted input transaction to the predictor.
  task automatic predict_tokens(input in_item_t it);
    case (it.op)
      OP_WR_BYTE: voc_bytes[it.idx][it.pos] = it.byte_val;
      OP_WR_LEN_ID: begin
        voc_len[it.idx] = it.len;
        voc_id[it.idx]  = it.tid;
      end
      OP_TEXT: begin
        if (win_cnt < WIN_LEN) begin
          win_q[win_cnt[4:0]] = it.byte_val;
          win_cnt++;
        end
        if (it.eot) begin
          // The drain always leaves at least one token, the flagged one last.
          while (win_cnt > 0) emit_token(1'b0);
          token_q[token_q.size() - 1].last = 1'b1;
        end else if (win_cnt >= WIN_LEN) begin
          emit_token(1'b0);
        end
      end
      default: ;
    endcase
  endtask

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 200);
  endfunction

  task automatic push_item(input logic [1:0] op, input logic [7:0] b, input logic eot,
                           input logic [9:0] idx, input logic [4:0] pos,
                           input logic [5:0] len, input logic [17:0] tid);
    in_item_t it;
    it.op = op; it.byte_val = b; it.eot = eot; it.idx = idx; it.pos = pos;
    it.len = len; it.tid = tid; it.drain_first = 1'b0;
    if (op == OP_WR_BYTE) gen_written[idx][pos] = 1'b1;
    pending_q = {pending_q, it};
  endtask

  // Loads an entry with a short string over the small text alphabet.
  task automatic load_entry(input logic [9:0] idx, input int unsigned n,
                            input logic [17:0] tid);
    for (int b = 0; b < n; b++)
      push_item(OP_WR_BYTE, 8'(8'h61 + $urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                idx, b[4:0], 6'($urandom), 18'($urandom));
    push_item(OP_WR_LEN_ID, 8'($urandom), 1'($urandom_range(0, 1)), idx, 5'($urandom),
              n[5:0], tid);
  endtask

  task automatic build_stimulus();
    int unsigned rnd_items;
    int unsigned n;
    int unsigned kind;
    logic [9:0]  idx;
    bit          paused;
    // Directed opening. Two entries with the same string check that the
    // higher index wins; a length beyond the window must never match.
    push_item(OP_WR_BYTE, 8'h61, 1'b0, 10'd5, 5'd0, '0, '0);
    push_item(OP_WR_BYTE, 8'h62, 1'b1, 10'd5, 5'd1, '0, '0);
    push_item(OP_WR_LEN_ID, 8'hFF, 1'b0, 10'd5, 5'd31, 6'd2, 18'h3FFFF);
    push_item(OP_WR_BYTE, 8'h61, 1'b0, 10'd1023, 5'd0, 6'd63, 18'h3FFFF);
    push_item(OP_WR_BYTE, 8'h62, 1'b0, 10'd1023, 5'd1, '0, '0);
    push_item(OP_WR_LEN_ID, 8'h00, 1'b1, 10'd1023, 5'd0, 6'd2, 18'd100);
    push_item(OP_WR_BYTE, 8'h61, 1'b0, 10'd0, 5'd0, '0, '0);
    push_item(OP_WR_LEN_ID, 8'h00, 1'b0, 10'd0, 5'd0, 6'd1, 18'd0);
    push_item(OP_WR_LEN_ID, 8'h00, 1'b0, 10'd9, 5'd0, 6'd40, 18'd7);
    push_item(OP_WR_LEN_ID, 8'h00, 1'b0, 10'd10, 5'd0, 6'd63, 18'd8);
    push_item(OP_WR_BYTE, 8'hFF, 1'b1, 10'd11, 5'd31, 6'd63, 18'h3FFFF);
    push_item(2'd3, 8'hFF, 1'b1, 10'd1023, 5'd31, 6'd63, 18'h3FFFF);
    push_item(OP_TEXT, 8'h61, 1'b0, '0, '0, '0, '0);
    push_item(OP_TEXT, 8'h62, 1'b0, 10'h3FF, 5'h1F, 6'h3F, 18'h3FFFF);
    push_item(OP_TEXT, 8'h61, 1'b0, '0, '0, '0, '0);
    push_item(OP_TEXT, 8'h63, 1'b1, '0, '0, '0, '0);
    push_item(OP_TEXT, 8'hFF, 1'b1, '0, '0, '0, '0);
    push_item(OP_TEXT, 8'h00, 1'b0, '0, '0, '0, '0);
    push_item(OP_TEXT, 8'h61, 1'b1, '0, '0, '0, '0);
    // Invalidate the winning duplicate so the lower index takes over.
    push_item(OP_WR_LEN_ID, 8'h00, 1'b0, 10'd1023, 5'd0, 6'd0, 18'd0);
    push_item(OP_TEXT, 8'h61, 1'b0, '0, '0, '0, '0);
    push_item(OP_TEXT, 8'h62, 1'b1, '0, '0, '0, '0);

    rnd_items = 0;
    paused    = 1'b0;
    while (rnd_items < 105) begin
      if (!paused && rnd_items > 50) begin
        push_item(OP_TEXT, 8'h61, 1'b1, '0, '0, '0, '0);
        pending_q[pending_q.size() - 1].drain_first = 1'b1;
        paused = 1'b1;
      end
      kind = $urandom_range(0, 99);
      if (kind < 25) begin
        n   = $urandom_range(1, 4);
        idx = ($urandom_range(0, 3) == 0) ? 10'($urandom_range(0, N_ENTRIES - 1))
                                          : 10'($urandom_range(0, 15));
        load_entry(idx, n, 18'($urandom));
        rnd_items += n + 1;
      end else if (kind < 33) begin
        case ($urandom_range(0, 2))
          0: push_item(2'd3, 8'($urandom), 1'($urandom), 10'($urandom), 5'($urandom),
                       6'($urandom), 18'($urandom));
          1: push_item(OP_WR_LEN_ID, 8'($urandom), 1'($urandom), 10'($urandom),
                       5'($urandom),
                       ($urandom_range(0, 1) ? 6'd0 : 6'($urandom_range(33, 63))),
                       18'($urandom));
          default: push_item(OP_WR_BYTE, 8'($urandom), 1'($urandom), 10'($urandom),
                             5'($urandom), 6'($urandom), 18'($urandom));
        endcase
        rnd_items++;
      end else begin
        // Text run: long enough now and then to fill the window.
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 40) : $urandom_range(1, 8);
        for (int i = 0; i < n; i++)
          push_item(OP_TEXT,
                    ($urandom_range(0, 9) == 0) ? 8'($urandom)
                                                : 8'(8'h61 + $urandom_range(0, 3)),
                    (i == n - 1) && ($urandom_range(0, 9) < 7),
                    10'($urandom), 5'($urandom), 6'($urandom), 18'($urandom));
        rnd_items += n;
      end
    end
    push_item(OP_TEXT, 8'($urandom), 1'b1, '0, '0, '0, '0);
  endtask

  // Driver: one transaction at a time from the pending queue.
  int unsigned drv_gap = 0;
  in_item_t    drv_item;
  logic        drv_valid_nx;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
    end else begin
      drv_valid_nx = s_axis_tvalid_i;
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        predict_tokens(drv_item);
        drv_valid_nx = 1'b0;
        drv_gap      = pick_gap();
      end
      if (!drv_valid_nx) begin
        if (drv_gap > 0) begin
          drv_gap--;
        end else if (pending_q.size() > 0 &&
                     !(pending_q[0].drain_first && token_q.size() != 0)) begin
          drv_item       = pending_q.pop_front();
          drv_valid_nx   = 1'b1;
          s_axis_tdata_i <= {1'b0, drv_item.tid, drv_item.len, drv_item.pos,
                             drv_item.idx, drv_item.byte_val};
          s_axis_tuser_i <= drv_item.op;
          s_axis_tlast_i <= drv_item.eot;
        end
      end
      s_axis_tvalid_i <= drv_valid_nx;
    end
  end

  // Monitor: random back-pressure, then field-by-field comparison.
  int unsigned mon_stall = 0;
  token_t      mon_exp;

  task automatic note_mismatch(input string what);
    err_cnt++;
    if (err_cnt <= MAX_ERR_PR)
      $display("mismatch %s: exp id=%h fb=%b last=%b, got data=%h fb=%b last=%b", what,
               mon_exp.tok_id, mon_exp.fallback, mon_exp.last,
               m_axis_tdata_o, m_axis_tuser_o, m_axis_tlast_o);
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (token_q.size() == 0) begin
          mon_exp = '{tok_id: '0, fallback: 1'b0, last: 1'b0};
          note_mismatch("unexpected token");
        end else begin
          mon_exp = token_q.pop_front();
          if (m_axis_tdata_o !== {6'd0, mon_exp.tok_id}) note_mismatch("token");
          else if (m_axis_tuser_o !== mon_exp.fallback) note_mismatch("is_fallback");
          else if (m_axis_tlast_o !== mon_exp.last) note_mismatch("last_of_run");
        end
      end
      if (mon_stall > 0) begin
        mon_stall--;
        m_axis_tready_i <= 1'b0;
      end else begin
        mon_stall = pick_gap();
        m_axis_tready_i <= (mon_stall == 0);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_CAP) begin
      $display("FAIL greedy_longest_match_tokenizer_core");
      $finish;
    end
  end

  initial begin
    win_cnt = 0;
    for (int b = 0; b < WIN_LEN; b++) win_q[b[4:0]] = 8'd0;
    for (int e = 0; e < N_ENTRIES; e++) begin
      voc_len[e[9:0]] = 6'd0;
      voc_id[e[9:0]]  = 18'd0;
      for (int b = 0; b < WIN_LEN; b++) begin
        voc_bytes[e[9:0]][b[4:0]]   = 8'd0;
        gen_written[e[9:0]][b[4:0]] = 1'b0;
      end
    end
    build_stimulus();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pending_q.size() == 0 && !s_axis_tvalid_i && token_q.size() == 0);
    repeat (3000) @(posedge clk_i);
    if (err_cnt == 0 && token_q.size() == 0) begin
      $display("PASS greedy_longest_match_tokenizer_core");
    end else begin
      $display("FAIL greedy_longest_match_tokenizer_core");
    end
    $finish;
  end

endmodule

### sim.f
rtl/glmt_pkg.sv
rtl/glmt_cell.sv
rtl/greedy_longest_match_tokenizer_core.sv
rtl/glmt_checker.sv
dv/greedy_longest_match_tokenizer_core_tb.sv
